@@ rtl/vn2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn2d_pkg
// Constants shared by the 2D value noise sampler: fixed-point format,
// hash multipliers and the fraction alignment to Q0.16.
// ----------------------------------------------------------------------------
package vn2d_pkg;

   // Fraction bits of the Q(32-FRAC_BITS).FRAC_BITS sample coordinates (8..24).
   localparam int FRAC_BITS = 16;

   // Alignment of the raw fraction to Q0.16.
   localparam int FRAC_SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int FRAC_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
   localparam logic [31:0] FRAC_MASK = 32'((64'd1 << FRAC_BITS) - 64'd1);

   // Hash multipliers.
   localparam logic [31:0] MUL_X   = 32'd73856093;
   localparam logic [31:0] MUL_Y   = 32'd19349663;
   localparam logic [31:0] MUL_MIX = 32'd1274126177;

   // Xorshift amount in the hash mix.
   localparam int MIX_SHIFT = 13;

   // One in Q0.16, and the smoothstep constant 3.0 in Q0.16.
   localparam logic [16:0] Q16_ONE   = 17'd65536;
   localparam logic [17:0] EASE_THREE = 18'd196608;

endpackage

@@ rtl/value_noise_2d_sampler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_sampler_core
// Two-dimensional value noise: lattice hashing of the four corners around a
// Q16.16 sample point, smoothstep easing and bilinear interpolation to Q0.16.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload (lowest bit up)
//  req      in         seed[31:0], sample_x[63:32], sample_y[95:64]
//  rsp      out        noise_value[15:0]
//
//  One beat is accepted and one result leaves per cycle while the output is not
//  stalled; each beat passes the five register stages (floor and lattice multiply,
//  corner combine and first ease multiply, mix and second ease multiply,
//  x blend, y blend).
//  Reset clears only the stage valid bits; data registers are not reset.
//  Each stage holds when it is full and the stage after it cannot take its
//  beat, so an empty stage still accepts while the output waits.
//
module value_noise_2d_sampler_core
   import vn2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // seed[31:0], sample_x[63:32], sample_y[95:64]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // noise_value[15:0]
);

   // Stage valid bits and per-stage advance enables.
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;
   logic ready1, ready2, ready3, ready4, ready5;

   assign ready5 = !valid5_ff || rsp_tready;
   assign ready4 = !valid4_ff || ready5;
   assign ready3 = !valid3_ff || ready4;
   assign ready2 = !valid2_ff || ready3;
   assign ready1 = !valid1_ff || ready2;

   assign req_tready = ready1;
   assign rsp_tvalid = valid5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= req_tvalid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
         if (ready4) valid4_ff <= valid3_ff;
         if (ready5) valid5_ff <= valid4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: floor, fraction, lattice coordinate multiplies.
   // ------------------------------------------------------------------------
   logic [31:0] seed, sample_x, sample_y;
   logic [31:0] ix, iy;
   logic [31:0] frac_x, frac_y;
   logic [31:0] seed1_in, hx1_in, hy1_in;
   logic [15:0] tx1_in, ty1_in;
   logic [31:0] seed1_ff, hx1_ff, hy1_ff;
   logic [15:0] tx1_ff, ty1_ff;

   always_comb begin
      seed     = req_tdata[31:0];
      sample_x = req_tdata[63:32];
      sample_y = req_tdata[95:64];
      ix       = 32'($signed(sample_x) >>> FRAC_BITS);
      iy       = 32'($signed(sample_y) >>> FRAC_BITS);
      frac_x   = sample_x & FRAC_MASK;
      frac_y   = sample_y & FRAC_MASK;
      tx1_in   = 16'((frac_x >> FRAC_SHR) << FRAC_SHL);
      ty1_in   = 16'((frac_y >> FRAC_SHR) << FRAC_SHL);
      seed1_in = seed;
      hx1_in   = ix * MUL_X;
      hy1_in   = iy * MUL_Y;
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         seed1_ff <= seed1_in;
         hx1_ff   <= hx1_in;
         hy1_ff   <= hy1_in;
         tx1_ff   <= tx1_in;
         ty1_ff   <= ty1_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: corner combine and first xorshift; square of each fraction.
   // The next corner's product is (i+1)*M = i*M + M, wrapping like the index.
   // ------------------------------------------------------------------------
   logic [31:0] hx_next, hy_next;
   logic [31:0] c00, c10, c01, c11;
   logic [31:0] c00_in, c10_in, c01_in, c11_in;
   logic [31:0] ttx2_in, tty2_in;
   logic [31:0] c00_ff, c10_ff, c01_ff, c11_ff;
   logic [31:0] ttx2_ff, tty2_ff;
   logic [15:0] tx2_ff, ty2_ff;

   always_comb begin
      hx_next = hx1_ff + MUL_X;
      hy_next = hy1_ff + MUL_Y;
      c00     = seed1_ff ^ hx1_ff  ^ hy1_ff;
      c10     = seed1_ff ^ hx_next ^ hy1_ff;
      c01     = seed1_ff ^ hx1_ff  ^ hy_next;
      c11     = seed1_ff ^ hx_next ^ hy_next;
      c00_in  = c00 ^ (c00 >> MIX_SHIFT);
      c10_in  = c10 ^ (c10 >> MIX_SHIFT);
      c01_in  = c01 ^ (c01 >> MIX_SHIFT);
      c11_in  = c11 ^ (c11 >> MIX_SHIFT);
      ttx2_in = {16'd0, tx1_ff} * {16'd0, tx1_ff};
      tty2_in = {16'd0, ty1_ff} * {16'd0, ty1_ff};
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         c00_ff  <= c00_in;
         c10_ff  <= c10_in;
         c01_ff  <= c01_in;
         c11_ff  <= c11_in;
         ttx2_ff <= ttx2_in;
         tty2_ff <= tty2_in;
         tx2_ff  <= tx1_ff;
         ty2_ff  <= ty1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: hash mix multiply and smoothstep t^2 * (3 - 2t).
   // After the final xorshift by 16 the top half is unchanged, so the lattice
   // value is simply the top 16 bits of the mixed product.
   // ------------------------------------------------------------------------
   logic [31:0] m00, m10, m01, m11;
   logic [17:0] kx, ky;
   logic [49:0] ex_prod, ey_prod;
   logic [15:0] v00_in, v10_in, v01_in, v11_in, fx_in, fy3_in;
   logic [15:0] v00_ff, v10_ff, v01_ff, v11_ff, fx_ff, fy3_ff;

   always_comb begin
      m00     = c00_ff * MUL_MIX;
      m10     = c10_ff * MUL_MIX;
      m01     = c01_ff * MUL_MIX;
      m11     = c11_ff * MUL_MIX;
      v00_in  = m00[31:16];
      v10_in  = m10[31:16];
      v01_in  = m01[31:16];
      v11_in  = m11[31:16];
      kx      = EASE_THREE - {1'b0, tx2_ff, 1'b0};
      ky      = EASE_THREE - {1'b0, ty2_ff, 1'b0};
      ex_prod = 50'(ttx2_ff) * 50'(kx);
      ey_prod = 50'(tty2_ff) * 50'(ky);
      fx_in   = (ex_prod[49:48] != 2'd0) ? 16'hFFFF : ex_prod[47:32];
      fy3_in  = (ey_prod[49:48] != 2'd0) ? 16'hFFFF : ey_prod[47:32];
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         v00_ff <= v00_in;
         v10_ff <= v10_in;
         v01_ff <= v01_in;
         v11_ff <= v11_in;
         fx_ff  <= fx_in;
         fy3_ff <= fy3_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: blend both rows along x.
   // ------------------------------------------------------------------------
   logic [16:0] wx;
   logic [32:0] acc_upper, acc_lower;
   logic [15:0] upper_in, lower_in;
   logic [15:0] upper_ff, lower_ff, fy4_ff;

   always_comb begin
      wx        = Q16_ONE - {1'b0, fx_ff};
      acc_upper = 33'(v00_ff) * 33'(wx) + 33'(v10_ff) * 33'(fx_ff);
      acc_lower = 33'(v01_ff) * 33'(wx) + 33'(v11_ff) * 33'(fx_ff);
      upper_in  = acc_upper[31:16];
      lower_in  = acc_lower[31:16];
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         upper_ff <= upper_in;
         lower_ff <= lower_in;
         fy4_ff   <= fy3_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 5: blend along y and saturate into the output register.
   // ------------------------------------------------------------------------
   logic [16:0] wy;
   logic [32:0] acc_out;
   logic [15:0] noise_in;
   logic [15:0] noise_ff;

   always_comb begin
      wy       = Q16_ONE - {1'b0, fy4_ff};
      acc_out  = 33'(upper_ff) * 33'(wy) + 33'(lower_ff) * 33'(fy4_ff);
      noise_in = acc_out[32] ? 16'hFFFF : acc_out[31:16];
   end

   always_ff @(posedge clock) begin
      if (ready5) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_tdata = noise_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_accept_fills_stage1 : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid1_ff)
      else $error("accepted beat did not reach the first stage");

   a_empty_stage1_ready : assert property (@(posedge clock) disable iff (reset)
      !valid1_ff |-> req_tready)
      else $error("input stalled with an empty first stage");

   a_open_output_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while the output is taking beats");

   a_stall_holds_result : assert property (@(posedge clock) disable iff (reset)
      (valid5_ff && !rsp_tready) |=> (valid5_ff && $stable(noise_ff)))
      else $error("held result changed or vanished during a stall");

endmodule

@@ tb/sv/value_noise_2d_sampler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_2d_sampler_core_tb
// Self-checking bench for the 2D value noise sampler. A bit-exact predictor
// computes the corner hashes, smoothstep easing and bilinear blend for every
// accepted sample beat, and the results are checked in order as they leave.
// Both stream sides idle and stall at random, with one calm stretch.
// ----------------------------------------------------------------------------
module value_noise_2d_sampler_core_tb
   import vn2d_pkg::*;
();

   localparam int SAMPLE_COUNT   = 1300;
   localparam int WATCHDOG_LIMIT = 5000;

   // Holds the expected noise values and checks results against them.
   class noise_scoreboard;
      logic [15:0] noise_expected_q[$];
      int unsigned mismatches;

      function logic [15:0] corner_level(logic [31:0] seed, logic [31:0] cx,
                                         logic [31:0] cy);
         logic [31:0] h;
         h = seed ^ (cx * MUL_X) ^ (cy * MUL_Y);
         h = h ^ (h >> 13);
         h = h * MUL_MIX;
         h = h ^ (h >> 16);
         return h[31:16];
      endfunction

      function logic [15:0] frac_to_q16(logic [31:0] p);
         logic [31:0] f;
         f = p & FRAC_MASK;
         if (FRAC_BITS >= 16) begin
            f = f >> (FRAC_BITS - 16);
         end else begin
            f = (f << (16 - FRAC_BITS)) & 32'h0000_FFFF;
         end
         return f[15:0];
      endfunction

      function logic [15:0] ease_fraction(logic [15:0] t);
         logic [63:0] tt;
         logic [63:0] k;
         logic [63:0] s;
         tt = 64'(t) * 64'(t);
         k  = 64'd196608 - 64'd2 * 64'(t);
         s  = (tt * k) >> 32;
         if (s > 64'hFFFF) begin
            s = 64'hFFFF;
         end
         return s[15:0];
      endfunction

      function logic [31:0] lerp_q16(logic [31:0] a, logic [31:0] b, logic [15:0] w);
         logic [63:0] acc;
         acc = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w);
         return acc[47:16];
      endfunction

      function logic [15:0] predict_noise(logic [31:0] seed, logic [31:0] px,
                                          logic [31:0] py);
         logic [31:0] ix, iy, ix1, iy1;
         logic [15:0] wx, wy;
         logic [31:0] upper, lower, r;
         ix  = 32'($signed(px) >>> FRAC_BITS);
         iy  = 32'($signed(py) >>> FRAC_BITS);
         ix1 = ix + 32'd1;
         iy1 = iy + 32'd1;
         wx  = ease_fraction(frac_to_q16(px));
         wy  = ease_fraction(frac_to_q16(py));
         upper = lerp_q16(32'(corner_level(seed, ix, iy)),
                          32'(corner_level(seed, ix1, iy)), wx);
         lower = lerp_q16(32'(corner_level(seed, ix, iy1)),
                          32'(corner_level(seed, ix1, iy1)), wx);
         r = lerp_q16(upper, lower, wy);
         if (r > 32'hFFFF) begin
            r = 32'hFFFF;
         end
         return r[15:0];
      endfunction

      function void note_sample(logic [31:0] seed, logic [31:0] px, logic [31:0] py);
         noise_expected_q = {noise_expected_q, predict_noise(seed, px, py)};
      endfunction

      function void check_noise(logic [15:0] actual);
         logic [15:0] want;
         if (noise_expected_q.size() == 0) begin
            mismatches++;
            $error("unexpected beat: noise_value actual %h with none expected", actual);
            return;
         end
         want = noise_expected_q.pop_front();
         if (actual !== want) begin
            mismatches++;
            $error("noise_value mismatch: expected %h actual %h", want, actual);
         end
      endfunction

      function int pending();
         return noise_expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;   // seed[31:0], sample_x[63:32], sample_y[95:64]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // noise_value[15:0]

   noise_scoreboard board = new;
   bit calm = 1'b0;   // no idling on either side while set

   value_noise_2d_sampler_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one sample beat and returns at the edge that accepts it.
   task automatic send_sample(input logic [31:0] seed, input logic [31:0] px,
                              input logic [31:0] py);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px, seed};
      do @(posedge clock); while (!req_tready);
      board.note_sample(seed, px, py);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Small signed coordinate, within a few lattice cells of the origin.
   function automatic logic [31:0] near_origin();
      logic [31:0] r;
      r = $urandom;
      return {{12{r[19]}}, r[19:0]};
   endfunction

   // Coordinate in the top or bottom lattice cell of the signed range.
   function automatic logic [31:0] near_edge();
      logic [31:0] r;
      r = $urandom;
      return {r[0] ? 16'h7FFF : 16'h8000, r[31:16]};
   endfunction

   task automatic run_random_samples();
      logic [31:0] scan_seed, scan_x, scan_y, scan_step;
      logic [31:0] px, py, seed;
      int scan_left;
      int kind;
      scan_left = 0;
      scan_seed = '0;
      scan_x    = '0;
      scan_y    = '0;
      scan_step = '0;
      for (int n = 0; n < SAMPLE_COUNT; n++) begin
         calm = (n >= 400 && n < 700);
         if (n == 900) begin
            hold_until_drained();
         end
         kind = $urandom_range(99);
         seed = $urandom;
         if (kind < 30) begin
            px = $urandom;
            py = $urandom;
         end else if (kind < 60) begin
            // A row of a map walked at a fixed step, as a generator would.
            if (scan_left == 0) begin
               scan_left = $urandom_range(4, 40);
               scan_seed = $urandom;
               scan_x    = $urandom_range(1) ? near_origin() : $urandom;
               scan_y    = $urandom_range(1) ? near_origin() : $urandom;
               scan_step = $urandom_range(1, 32'h0002_0000);
            end
            scan_left--;
            seed   = scan_seed;
            scan_x = scan_x + scan_step;
            px     = scan_x;
            py     = scan_y;
         end else if (kind < 80) begin
            px = near_origin();
            py = near_origin();
         end else begin
            px = near_edge();
            py = $urandom_range(1) ? near_edge() : near_origin();
         end
         send_sample(seed, px, py);
      end
      calm = 1'b0;
   endtask

   // Result side: checks each accepted beat and stalls at random.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            board.check_noise(rsp_tdata);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // Ends the run when nothing moves on either side for too long.
   initial begin
      int still_cycles;
      still_cycles = 0;
      while (still_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
            still_cycles = 0;
         end else begin
            still_cycles++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples: range extremes, wrapping corners, negative
      // floors, exact lattice points and the largest fractions.
      send_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
      send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(32'hA5A5_A5A5, 32'h8000_0000, 32'h8000_0000);
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_0000);
      send_sample(32'h5A5A_5A5A, 32'h0000_FFFF, 32'h0000_FFFF);
      send_sample(32'h5A5A_5A5A, 32'h0000_8000, 32'h0000_8000);
      send_sample(32'hDEAD_BEEF, 32'h0001_0000, 32'h0000_0001);
      send_sample(32'hDEAD_BEEF, 32'hFFFF_8000, 32'h0000_7FFF);
      send_sample(32'h1357_9BDF, 32'h7FFF_0000, 32'h7FFF_FFFF);
      send_sample(32'h1357_9BDF, 32'h8000_0001, 32'hFFFF_FFFE);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0001);
      send_sample(32'h0000_0001, 32'h0000_0001, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h1234_5678, 32'h8765_4321);

      run_random_samples();
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
